@@ hdl/base36_five_bit_packer_top_macros.svh @@
// Assertion macros used by the checker of the base36 five-bit packer.
`ifndef BASE36_FIVE_BIT_PACKER_TOP_MACROS_SVH
`define BASE36_FIVE_BIT_PACKER_TOP_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define B36P_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define B36P_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/b36p_pkg.sv @@
// Package with the types, constants and widths of the base36 five-bit packer.
package b36p_pkg;

	// Message layout.
	localparam int MAX_VARYING = 4096;
	localparam int TAIL_BYTES  = 8;

	// Field widths of the transfers.
	localparam int CH_W   = 8;
	localparam int LEN_W  = 13;
	localparam int ADDR_W = 13;

	// Internal widths that follow from the message layout.
	localparam int N_W     = $clog2(MAX_VARYING + 1);
	localparam int SAT_W   = (N_W > LEN_W) ? N_W : LEN_W;
	localparam int CPOS_W  = $clog2(5 * MAX_VARYING + 1);
	localparam int EPOS_W  = $clog2(8 * MAX_VARYING + 1);
	localparam int TBASE_W = EPOS_W - 3;
	localparam int TIDX_W  = 4;
	localparam int HB_W    = 2;

	// Code packing.
	localparam int CODE_W = 5;
	localparam int ESC_W  = 3;
	localparam logic [CODE_W-1:0] ESCAPE_CODE = 5'd31;
	localparam logic [CH_W-1:0] ESCAPE_WIDE   = 8'd31;
	localparam logic [CH_W-1:0] CHAR_A        = 8'h61;
	localparam logic [CH_W-1:0] CHAR_ZERO     = 8'h30;
	localparam logic [CH_W-1:0] DIGIT_BASE    = 8'd26;

	// Header format.
	localparam int LONG_HEADER_MIN       = 128;
	localparam logic [CH_W-1:0] HDR_MARK = 8'h80;
	localparam logic [CH_W-1:0] HDR_LOW  = 8'h7f;

	// Depth of the job queue between the front and back parts.
	localparam int JOB_DEPTH = 4;
	localparam int JPTR_W    = $clog2(JOB_DEPTH);
	localparam int JCNT_W    = $clog2(JOB_DEPTH + 1);

	typedef struct packed {
		logic [CH_W-1:0]  char_byte;
		logic [LEN_W-1:0] message_length;
		logic             first_byte;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] byte_address;
		logic [CH_W-1:0]   or_value;
		logic [ADDR_W-1:0] total_length;
		logic              message_done;
		logic              last_of_item;
	} result_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CODE,
		KIND_ESC,
		KIND_TAIL
	} job_kind_t;

	// One classified input byte, ready to be expanded into byte writes.
	typedef struct packed {
		logic [1:0]        hdr_cnt;
		logic [N_W-1:0]    n;
		logic [HB_W-1:0]   hdr_bytes;
		job_kind_t         kind;
		logic [CPOS_W-1:0] code_pos;
		logic [CODE_W-1:0] code;
		logic [EPOS_W-1:0] esc_pos;
		logic [ESC_W-1:0]  esc;
		logic [ADDR_W-1:0] tail_off;
		logic [CH_W-1:0]   tail_byte;
		logic              done;
		logic [ADDR_W-1:0] total;
	} job_t;

endpackage

@@ hdl/b36p_front.sv @@
// Front part: tracks message state and turns each accepted byte into a job.
module b36p_front
	import b36p_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  request_t request,
	output logic     job_push,
	output job_t     job
);

	logic [N_W-1:0]     left_q;
	logic [CPOS_W-1:0]  cpos_q;
	logic [EPOS_W-1:0]  epos_q;
	logic [HB_W-1:0]    hb_q;
	logic [TIDX_W-1:0]  tidx_q;
	logic [TBASE_W-1:0] tbase_q;
	logic               busy_q;

	logic [SAT_W-1:0]   len_ext;
	logic [SAT_W-1:0]   n_wide;
	logic [N_W-1:0]     n;
	logic [N_W:0]       eff;
	logic [N_W-1:0]     cur_left;
	logic [CPOS_W-1:0]  cur_cpos;
	logic [EPOS_W-1:0]  cur_epos;
	logic [HB_W-1:0]    cur_hb;
	logic [TIDX_W-1:0]  cur_tidx;
	logic [TBASE_W-1:0] cur_tbase;
	logic               cur_busy;
	logic [CH_W-1:0]    code8;
	logic               is_esc;
	logic [EPOS_W-1:0]  new_epos;
	logic [TBASE_W-1:0] new_tbase;
	logic [TIDX_W:0]    tidx_inc;
	logic               job_valid;
	logic [N_W-1:0]     nxt_left;
	logic [CPOS_W-1:0]  nxt_cpos;
	logic [EPOS_W-1:0]  nxt_epos;
	logic [TIDX_W-1:0]  nxt_tidx;
	logic [TBASE_W-1:0] nxt_tbase;
	logic               nxt_busy;

	// Varying length of a new message, clamped at both ends.
	always_comb begin
		len_ext = SAT_W'(request.message_length);
		n_wide  = (len_ext >= SAT_W'(TAIL_BYTES)) ? len_ext - SAT_W'(TAIL_BYTES) : '0;
		n       = (n_wide > SAT_W'(MAX_VARYING)) ? N_W'(MAX_VARYING) : N_W'(n_wide);
		eff     = {1'b0, n} + (N_W + 1)'(TAIL_BYTES);
	end

	// State seen by this byte: fresh on a first byte, stored otherwise.
	always_comb begin
		if (request.first_byte) begin
			cur_left  = n;
			cur_cpos  = '0;
			cur_epos  = EPOS_W'({n, 2'b00}) + EPOS_W'(n);
			cur_hb    = (eff >= (N_W + 1)'(LONG_HEADER_MIN)) ? HB_W'(2) : HB_W'(1);
			cur_tidx  = '0;
			cur_tbase = '0;
			cur_busy  = 1'b1;
		end else begin
			cur_left  = left_q;
			cur_cpos  = cpos_q;
			cur_epos  = epos_q;
			cur_hb    = hb_q;
			cur_tidx  = tidx_q;
			cur_tbase = tbase_q;
			cur_busy  = busy_q;
		end
	end

	// Character code and the advance of the escape region.
	always_comb begin
		code8     = (request.char_byte >= CHAR_A) ? request.char_byte - CHAR_A
		                                          : request.char_byte - CHAR_ZERO + DIGIT_BASE;
		is_esc    = (code8 >= ESCAPE_WIDE);
		new_epos  = cur_epos + (is_esc ? EPOS_W'(ESC_W) : '0);
		new_tbase = TBASE_W'(new_epos >> 3) + TBASE_W'(|new_epos[2:0]);
		tidx_inc  = {1'b0, cur_tidx} + (TIDX_W + 1)'(1);
	end

	// Job contents and the next state.
	always_comb begin
		job.hdr_cnt   = request.first_byte ? 2'(cur_hb) : 2'd0;
		job.n         = n;
		job.hdr_bytes = cur_hb;
		job.kind      = KIND_NONE;
		job.code_pos  = cur_cpos;
		job.code      = is_esc ? ESCAPE_CODE : code8[CODE_W-1:0];
		job.esc_pos   = cur_epos;
		job.esc       = ESC_W'(code8 - ESCAPE_WIDE);
		job.tail_off  = ADDR_W'(cur_tbase) + ADDR_W'(cur_tidx);
		job.tail_byte = request.char_byte;
		job.done      = 1'b0;
		job.total     = '0;
		job_valid     = 1'b0;
		nxt_left      = cur_left;
		nxt_cpos      = cur_cpos;
		nxt_epos      = cur_epos;
		nxt_tidx      = cur_tidx;
		nxt_tbase     = cur_tbase;
		nxt_busy      = cur_busy;
		if (request.first_byte && (eff == '0)) begin
			// Empty message: the header write alone closes it.
			job_valid = 1'b1;
			job.done  = 1'b1;
			job.total = ADDR_W'(cur_hb) + ADDR_W'(TAIL_BYTES);
			nxt_busy  = 1'b0;
		end else if (cur_busy) begin
			job_valid = 1'b1;
			if (cur_left != '0) begin
				job.kind = is_esc ? KIND_ESC : KIND_CODE;
				nxt_cpos = cur_cpos + CPOS_W'(CODE_W);
				nxt_epos = new_epos;
				nxt_left = cur_left - N_W'(1);
				if (cur_left == N_W'(1)) begin
					nxt_tbase = new_tbase;
					if (TAIL_BYTES == 0) begin
						job.done  = 1'b1;
						job.total = ADDR_W'(cur_hb) + ADDR_W'(new_tbase)
						          + ADDR_W'(TAIL_BYTES);
						nxt_busy  = 1'b0;
					end
				end
			end else begin
				job.kind = KIND_TAIL;
				nxt_tidx = TIDX_W'(tidx_inc);
				if (tidx_inc >= (TIDX_W + 1)'(TAIL_BYTES)) begin
					job.done  = 1'b1;
					job.total = ADDR_W'(cur_hb) + ADDR_W'(cur_tbase) + ADDR_W'(TAIL_BYTES);
					nxt_busy  = 1'b0;
				end
			end
		end
		job_push = accept && job_valid;
	end

	// Message state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			cpos_q  <= '0;
			epos_q  <= '0;
			hb_q    <= '0;
			tidx_q  <= '0;
			tbase_q <= '0;
			busy_q  <= 1'b0;
		end else if (accept) begin
			left_q  <= nxt_left;
			cpos_q  <= nxt_cpos;
			epos_q  <= nxt_epos;
			hb_q    <= cur_hb;
			tidx_q  <= nxt_tidx;
			tbase_q <= nxt_tbase;
			busy_q  <= nxt_busy;
		end
	end

endmodule

@@ hdl/b36p_job_fifo.sv @@
// Short queue of jobs between the front and back parts.
module b36p_job_fifo
	import b36p_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output logic full,
	output logic avail,
	output job_t rd_data
);

	job_t              slots_q [JOB_DEPTH];
	logic [JPTR_W-1:0] wr_ptr_q;
	logic [JPTR_W-1:0] rd_ptr_q;
	logic [JCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	// Queue status and head entry.
	always_comb begin
		full    = (count_q == JCNT_W'(JOB_DEPTH));
		avail   = (count_q != '0);
		do_wr   = wr_en && !full;
		do_rd   = rd_en && avail;
		rd_data = slots_q[rd_ptr_q];
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JPTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + JPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JPTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + JPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + JCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - JCNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/b36p_back.sv @@
// Back part: expands jobs to byte writes in an output register, one per cycle if free.
module b36p_back
	import b36p_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_avail,
	input  job_t    job,
	output logic    job_take,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	typedef enum logic [2:0] {
		SLOT_HDR0,
		SLOT_HDR1,
		SLOT_CODE0,
		SLOT_CODE1,
		SLOT_ESC0,
		SLOT_ESC1,
		SLOT_TAIL
	} slot_t;

	slot_t   slot_q;
	logic    mid_q;
	logic    out_valid_q;
	result_t out_q;

	slot_t             first_slot;
	slot_t             after_hdr;
	slot_t             cur_slot;
	slot_t             next_slot;
	logic              next_valid;
	logic              use_esc;
	logic [EPOS_W-1:0] pos;
	logic [15:0]       field;
	logic [15:0]       shifted;
	logic [ADDR_W-1:0] base;
	result_t           wr;
	logic              advance;

	// Order of the writes inside one job.
	always_comb begin
		after_hdr  = (job.kind == KIND_TAIL) ? SLOT_TAIL : SLOT_CODE0;
		first_slot = (job.hdr_cnt != 2'd0) ? SLOT_HDR0 : after_hdr;
		cur_slot   = mid_q ? slot_q : first_slot;
		next_slot  = cur_slot;
		next_valid = 1'b0;
		unique case (cur_slot)
			SLOT_HDR0: begin
				if (job.hdr_cnt == 2'd2) begin
					next_slot  = SLOT_HDR1;
					next_valid = 1'b1;
				end else begin
					next_slot  = after_hdr;
					next_valid = (job.kind != KIND_NONE);
				end
			end
			SLOT_HDR1: begin
				next_slot  = after_hdr;
				next_valid = (job.kind != KIND_NONE);
			end
			SLOT_CODE0: begin
				next_slot  = SLOT_CODE1;
				next_valid = 1'b1;
			end
			SLOT_CODE1: begin
				next_slot  = SLOT_ESC0;
				next_valid = (job.kind == KIND_ESC);
			end
			SLOT_ESC0: begin
				next_slot  = SLOT_ESC1;
				next_valid = 1'b1;
			end
			default: begin
				next_valid = 1'b0;
			end
		endcase
	end

	// Bit packing of a 5-bit code or a 3-bit escape value.
	always_comb begin
		use_esc = (cur_slot == SLOT_ESC0) || (cur_slot == SLOT_ESC1);
		pos     = use_esc ? job.esc_pos : EPOS_W'(job.code_pos);
		field   = use_esc ? 16'({job.esc, 13'b0}) : 16'({job.code, 11'b0});
		shifted = field >> pos[2:0];
		base    = ADDR_W'(job.hdr_bytes) + ADDR_W'(pos >> 3);
	end

	// The write of the current slot.
	always_comb begin
		wr.byte_address = '0;
		wr.or_value     = '0;
		unique case (cur_slot)
			SLOT_HDR0: begin
				wr.or_value = (job.hdr_cnt == 2'd2) ? (CH_W'(job.n >> 7) | HDR_MARK)
				                                    : CH_W'(job.n);
			end
			SLOT_HDR1: begin
				wr.byte_address = ADDR_W'(1);
				wr.or_value     = CH_W'(job.n) & HDR_LOW;
			end
			SLOT_CODE0, SLOT_ESC0: begin
				wr.byte_address = base;
				wr.or_value     = shifted[15:8];
			end
			SLOT_CODE1, SLOT_ESC1: begin
				wr.byte_address = base + ADDR_W'(1);
				wr.or_value     = shifted[7:0];
			end
			default: begin
				wr.byte_address = ADDR_W'(job.hdr_bytes) + job.tail_off;
				wr.or_value     = job.tail_byte;
			end
		endcase
		wr.last_of_item = !next_valid;
		wr.message_done = job.done && !next_valid;
		wr.total_length = wr.message_done ? job.total : '0;
		advance         = job_avail && (!out_valid_q || pop);
		job_take        = advance && !next_valid;
		empty           = !out_valid_q;
		result          = out_q;
	end

	// Slot sequencing, output valid and output payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_HDR0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (advance) begin
				slot_q      <= next_slot;
				mid_q       <= next_valid;
				out_valid_q <= 1'b1;
				out_q       <= wr;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/base36_five_bit_packer_top.sv @@
// Top level of the base36 five-bit packer: front part, job queue and back part.
// Each accepted byte of an open message is queued as a job, whose writes go to the output register.
// One byte write per cycle while the result is free or popped; a byte of an open message gives
// 1 to 6 writes: 2 for a plain character, 4 for an escaped one, 1 for a tail byte, plus 1 or 2
// header writes on a first byte; the single write port sets the rate, a 4-entry queue absorbs bursts.
// Reset (arst_n low) closes any open message and empties the queue and the output register.
module base36_five_bit_packer_top
	import b36p_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  request_t request,
	input  logic     pop,
	output logic     empty,
	output result_t  result
);

	logic accept;
	logic job_push;
	job_t job_in;
	logic job_avail;
	job_t job_head;
	logic job_take;

	// An input transfer completes when the job queue has room.
	assign accept = push && !full;

	b36p_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.job_push (job_push),
		.job      (job_in)
	);

	b36p_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.rd_en   (job_take),
		.full    (full),
		.avail   (job_avail),
		.rd_data (job_head)
	);

	b36p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job       (job_head),
		.job_take  (job_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

@@ hdl/b36p_checker.sv @@
// Port checker for the base36 five-bit packer and its bind to the top level.
`include "base36_five_bit_packer_top_macros.svh"

module b36p_checker
	import b36p_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     pop,
	input logic     empty,
	input result_t  result
);

	// A waiting result that is not taken stays put.
	`B36P_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "result changed while stalled")

	// The total length is given only on the final write of a message.
	`B36P_ASSERT_NOW(a_total_only_done, !empty && !result.message_done, result.total_length == '0, "total length off the final write")

	// The final write of a message is also the last write of its byte.
	`B36P_ASSERT_NOW(a_done_is_last, !empty && result.message_done, result.last_of_item, "message done without last of item")

	// A finished message always holds at least its header byte.
	`B36P_ASSERT_NOW(a_done_total_nonzero, !empty && result.message_done, result.total_length != '0, "message done with zero total length")

endmodule

bind base36_five_bit_packer_top b36p_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.pop     (pop),
	.empty   (empty),
	.result  (result)
);
